FILE: rtl/core/word_frequency_table_unit_assert.svh
// Assertion macros shared by the word frequency table modules.
`ifndef WORD_FREQUENCY_TABLE_UNIT_ASSERT_SVH
`define WORD_FREQUENCY_TABLE_UNIT_ASSERT_SVH

// Checks that a condition implies a consequence on the same edge.
`define WFT_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence on the next edge.
`define WFT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/wft_pkg.sv
package wft_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic take_char;
    logic close_word;
    logic scan_start;
    logic scan_step;
    logic cmp_start;
    logic cmp_step;
    logic do_update;
    logic do_insert;
    logic do_full;
    logic copy_step;
    logic rd_count;
  } wft_cmd_t;

  typedef struct packed {
    logic word_empty;
    logic scan_done;
    logic len_match;
    logic cmp_done;
    logic cmp_mismatch;
    logic table_full;
    logic copy_done;
  } wft_sts_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CLOSE  = 9'b000000010,
    ST_ENTRY  = 9'b000000100,
    ST_LEN    = 9'b000001000,
    ST_CMP    = 9'b000010000,
    ST_RDCNT  = 9'b000100000,
    ST_UPDATE = 9'b001000000,
    ST_COPY   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } wft_state_t;

  function automatic logic is_trail_mark(input logic [7:0] c);
    return (c == CHAR_COMMA) || (c == CHAR_COLON) || (c == CHAR_SEMI) || (c == CHAR_DOT);
  endfunction

endpackage

FILE: rtl/core/wft_datapath.sv
module wft_datapath #(
  parameter int TABLE_ENTRIES  = 64,
  parameter int MAX_WORD_CHARS = 16,
  parameter int COUNT_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fold_case,
  input  logic [7:0]          in_char,
  input  wft_pkg::wft_cmd_t   cmd,
  output wft_pkg::wft_sts_t   sts,
  output logic                char_is_space,
  output logic [5:0]          res_index,
  output logic [15:0]         res_count,
  output logic                res_new,
  output logic                res_full,
  output logic                res_cut
);

  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_WORD_CHARS);
  localparam int LW = $clog2(MAX_WORD_CHARS + 1);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = EW + CW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [7:0] word_mem [MAX_WORD_CHARS];
  logic [7:0] char_mem [TABLE_ENTRIES << CW];
  logic [LW-1:0] len_mem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];

  logic [LW-1:0] wlen_r;
  logic          ovf_r;
  logic [LW-1:0] n_r;
  logic          cut_r;
  logic [UW-1:0] used_r;
  logic [UW-1:0] ent_r;
  logic [LW-1:0] k_r;
  logic [7:0]    tbl_rd_r;
  logic [7:0]    wrd_rd_r;
  logic [LW-1:0] len_rd_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic          mism_r;
  logic [5:0]    res_index_r;
  logic [15:0]   res_count_r;
  logic          res_new_r;
  logic          res_full_r;

  logic [7:0]    ch;
  logic [LW-1:0] n_nxt;
  logic [COUNT_BITS-1:0] cnt_upd;

  always_comb begin
    ch = in_char;
    if (fold_case && in_char >= wft_pkg::CHAR_UPPER_A && in_char <= wft_pkg::CHAR_UPPER_Z) begin
      ch = in_char + wft_pkg::CASE_OFFSET;
    end
  end

  assign char_is_space = (in_char == wft_pkg::CHAR_SPACE);

  always_comb begin
    n_nxt = wlen_r;
    if (!ovf_r && wlen_r != '0 &&
        wft_pkg::is_trail_mark(word_mem[CW'(wlen_r - LW'(1))])) begin
      n_nxt = wlen_r - LW'(1);
    end
  end

  assign cnt_upd = (cnt_rd_r == COUNT_MAX) ? cnt_rd_r : cnt_rd_r + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.take_char && !char_is_space && wlen_r < LW'(MAX_WORD_CHARS)) begin
      word_mem[CW'(wlen_r)] <= ch;
    end
    if (cmd.copy_step) begin
      char_mem[AW'({ent_r[EW-1:0], CW'(k_r)})] <= word_mem[CW'(k_r)];
    end
    tbl_rd_r <= char_mem[AW'({ent_r[EW-1:0], CW'(k_r)})];
    wrd_rd_r <= word_mem[CW'(k_r)];
    len_rd_r <= len_mem[ent_r[EW-1:0]];
    if (cmd.rd_count) begin
      cnt_rd_r <= cnt_mem[ent_r[EW-1:0]];
    end
    if (cmd.do_update) begin
      cnt_mem[ent_r[EW-1:0]] <= cnt_upd;
    end
    if (cmd.do_insert) begin
      cnt_mem[ent_r[EW-1:0]] <= COUNT_BITS'(1);
      len_mem[ent_r[EW-1:0]] <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= '0;
      ovf_r  <= 1'b0;
      used_r <= '0;
    end else begin
      if (cmd.take_char && !char_is_space) begin
        if (wlen_r < LW'(MAX_WORD_CHARS)) begin
          wlen_r <= wlen_r + LW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.close_word) begin
        wlen_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (cmd.do_insert) begin
        used_r <= used_r + UW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close_word) begin
      n_r   <= n_nxt;
      cut_r <= ovf_r;
    end
    if (cmd.scan_start) begin
      ent_r <= '0;
    end else if (cmd.scan_step) begin
      ent_r <= ent_r + UW'(1);
    end else if (cmd.do_insert) begin
      ent_r <= ent_r;
    end
    if (cmd.cmp_start) begin
      k_r    <= '0;
      mism_r <= 1'b0;
    end else if (cmd.cmp_step) begin
      k_r <= k_r + LW'(1);
      if (k_r != '0 && tbl_rd_r != wrd_rd_r) begin
        mism_r <= 1'b1;
      end
    end else if (cmd.copy_step) begin
      k_r <= k_r + LW'(1);
    end
    if (cmd.do_update) begin
      res_index_r <= 6'(ent_r);
      res_count_r <= 16'(cnt_upd);
      res_new_r   <= 1'b0;
      res_full_r  <= 1'b0;
    end else if (cmd.do_insert) begin
      res_index_r <= 6'(used_r);
      res_count_r <= 16'd1;
      res_new_r   <= 1'b1;
      res_full_r  <= 1'b0;
    end else if (cmd.do_full) begin
      res_index_r <= '0;
      res_count_r <= '0;
      res_new_r   <= 1'b0;
      res_full_r  <= 1'b1;
    end
  end

  always_comb begin
    sts.word_empty   = (n_r == '0);
    sts.scan_done    = (ent_r >= used_r);
    sts.len_match    = (len_rd_r == n_r);
    sts.cmp_done     = (k_r == n_r);
    sts.cmp_mismatch = mism_r || (k_r != '0 && tbl_rd_r != wrd_rd_r);
    sts.table_full   = (used_r == UW'(TABLE_ENTRIES));
    sts.copy_done    = (k_r == n_r);
  end

  assign res_index = res_index_r;
  assign res_count = res_count_r;
  assign res_new   = res_new_r;
  assign res_full  = res_full_r;
  assign res_cut   = cut_r;

endmodule

FILE: rtl/core/wft_ctrl.sv
module wft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_end,
  input  logic              char_is_space,
  input  logic              out_stall,
  input  wft_pkg::wft_sts_t sts,
  output wft_pkg::wft_cmd_t cmd,
  output logic              in_stall,
  output logic              out_valid,
  output logic              last_entry
);

  wft_pkg::wft_state_t state_r, state_nxt;
  logic at_last_r, at_last_nxt;

  assign in_stall  = (state_r != wft_pkg::ST_IDLE);
  assign out_valid = (state_r == wft_pkg::ST_OUT);
  assign last_entry = at_last_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    at_last_nxt = at_last_r;
    case (state_r)
      wft_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.take_char = 1'b1;
          if (char_is_space || in_end) begin
            state_nxt = wft_pkg::ST_CLOSE;
          end
        end
      end
      wft_pkg::ST_CLOSE: begin
        cmd.close_word = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt = wft_pkg::ST_ENTRY;
      end
      wft_pkg::ST_ENTRY: begin
        if (sts.word_empty) begin
          state_nxt = wft_pkg::ST_IDLE;
        end else if (sts.scan_done) begin
          if (sts.table_full) begin
            cmd.do_full = 1'b1;
            state_nxt = wft_pkg::ST_OUT;
          end else begin
            cmd.cmp_start = 1'b1;
            state_nxt = wft_pkg::ST_COPY;
          end
        end else begin
          state_nxt = wft_pkg::ST_LEN;
        end
      end
      wft_pkg::ST_LEN: begin
        if (sts.len_match) begin
          cmd.cmp_start = 1'b1;
          state_nxt = wft_pkg::ST_CMP;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = wft_pkg::ST_ENTRY;
        end
      end
      wft_pkg::ST_CMP: begin
        if (sts.cmp_mismatch) begin
          cmd.scan_step = 1'b1;
          state_nxt = wft_pkg::ST_ENTRY;
        end else if (sts.cmp_done) begin
          cmd.rd_count = 1'b1;
          state_nxt = wft_pkg::ST_RDCNT;
        end else begin
          cmd.cmp_step = 1'b1;
        end
      end
      wft_pkg::ST_RDCNT: begin
        state_nxt = wft_pkg::ST_UPDATE;
      end
      wft_pkg::ST_UPDATE: begin
        cmd.do_update = 1'b1;
        state_nxt = wft_pkg::ST_OUT;
      end
      wft_pkg::ST_COPY: begin
        if (sts.copy_done) begin
          cmd.do_insert = 1'b1;
          state_nxt = wft_pkg::ST_OUT;
        end else begin
          cmd.copy_step = 1'b1;
        end
      end
      wft_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = wft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wft_pkg::ST_IDLE;
      end
    endcase
    at_last_nxt = sts.scan_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= wft_pkg::ST_IDLE;
      at_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      at_last_r <= at_last_nxt;
    end
  end

  `include "word_frequency_table_unit_assert.svh"

  `WFT_ASSERT_IMPL(a_busy_stalls, clk, rst_n, state_r != wft_pkg::ST_IDLE, in_stall)
  `WFT_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid)
  `WFT_ASSERT_IMPL(a_one_action, clk, rst_n, 1'b1,
    $onehot0({cmd.do_update, cmd.do_insert, cmd.do_full}))

endmodule

FILE: rtl/core/word_frequency_table_unit.sv
// Word frequency table unit.
// Input channel: in_valid/in_stall carries one text byte (in_text_char) and
// an end flag (in_end_of_text) per transaction. Output channel:
// out_valid/out_stall carries one result transaction per closed nonempty
// word: entry index, occurrence count, new-word, table-full and truncation
// flags. Configuration: cfg_we writes cfg_fold_case; the user must assert
// cfg_we only while idle, which the block itself does not enforce. A word
// character is taken while idle. A space or end mark starts a search that
// walks the table one entry at a time: the stored length is checked (ST_ENTRY,
// ST_LEN) and, on equal length, the characters are compared (ST_CMP); a match
// reads and updates the count (ST_RDCNT, ST_UPDATE), a miss inserts the word
// (ST_COPY) or flags a full table, and ST_OUT hands over the result. The serial
// table walk sets the latency. One item is handled at a time; in_stall is high
// while a word is processed and while a result waits. A stalled result holds
// its value on the outputs. Synchronous reset empties the table, clears the
// current word and sets fold_case to one.
module word_frequency_table_unit #(
  parameter int TABLE_ENTRIES  = 64,
  parameter int MAX_WORD_CHARS = 16,
  parameter int COUNT_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_fold_case,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_char,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_entry_index,
  output logic [15:0] out_occurrences,
  output logic        out_is_new_word,
  output logic        out_table_full,
  output logic        out_word_truncated
);

  wft_pkg::wft_cmd_t cmd;
  wft_pkg::wft_sts_t sts;
  logic fold_r;
  logic is_space;
  logic last_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r <= 1'b1;
    end else if (cfg_we) begin
      fold_r <= cfg_fold_case;
    end
  end

  wft_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_WORD_CHARS(MAX_WORD_CHARS), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .fold_case(fold_r), .in_char(in_text_char), .cmd(cmd),
    .sts(sts), .char_is_space(is_space), .res_index(out_entry_index),
    .res_count(out_occurrences), .res_new(out_is_new_word), .res_full(out_table_full),
    .res_cut(out_word_truncated)
  );

  wft_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_end(in_end_of_text),
    .char_is_space(is_space), .out_stall(out_stall), .sts(sts), .cmd(cmd),
    .in_stall(in_stall), .out_valid(out_valid), .last_entry(last_entry)
  );

  `include "word_frequency_table_unit_assert.svh"

  `WFT_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, out_valid, in_stall)
  `WFT_ASSERT_IMPL(a_new_not_full, clk, rst_n, out_valid, !(out_is_new_word && out_table_full))
  `WFT_ASSERT_IMPL(a_full_zero, clk, rst_n, out_valid && out_table_full && !last_entry,
    out_occurrences == 16'd0)

endmodule
